/* hw/rtl/sicx_pkg.sv */
// Shared types, opcodes, control word layout and microcode table of the SIC subset core.
package sicx_pkg;

	localparam int ADDR_W   = 16;
	localparam int WORD_W   = 24;
	localparam int BYTE_W   = 8;
	localparam int UPC_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	typedef logic [UPC_W-1:0] upc_t;

	// Request kinds carried on tuser.
	typedef enum logic [1:0] {
		K_WRITE   = 2'd0,
		K_READ    = 2'd1,
		K_RESTART = 2'd2,
		K_STEP    = 2'd3
	} kind_t;

	// Configuration register select (paddr bit 2).
	localparam logic REG_START = 1'b0;
	localparam logic REG_LEN   = 1'b1;

	// Instruction opcodes.
	localparam logic [BYTE_W-1:0] OP_LDA  = 8'h00;
	localparam logic [BYTE_W-1:0] OP_LDX  = 8'h04;
	localparam logic [BYTE_W-1:0] OP_STA  = 8'h0C;
	localparam logic [BYTE_W-1:0] OP_STX  = 8'h10;
	localparam logic [BYTE_W-1:0] OP_ADD  = 8'h18;
	localparam logic [BYTE_W-1:0] OP_SUB  = 8'h1C;
	localparam logic [BYTE_W-1:0] OP_COMP = 8'h28;
	localparam logic [BYTE_W-1:0] OP_JEQ  = 8'h30;
	localparam logic [BYTE_W-1:0] OP_JGT  = 8'h34;
	localparam logic [BYTE_W-1:0] OP_JLT  = 8'h38;

	// Condition codes.
	localparam logic [1:0] CC_EQ = 2'd0;
	localparam logic [1:0] CC_GT = 2'd1;
	localparam logic [1:0] CC_LT = 2'd2;

	localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		OPC_LOAD  = 2'd0,
		OPC_STORE = 2'd1,
		OPC_OTHER = 2'd2
	} opc_t;

	typedef enum logic [3:0] {
		JMP_SEQ      = 4'd0,
		JMP_GOTO     = 4'd1,
		JMP_WAIT_MOD = 4'd2,
		JMP_WAIT_IN  = 4'd3,
		JMP_WAIT_OUT = 4'd4,
		JMP_CLR      = 4'd5,
		JMP_HALT     = 4'd6,
		JMP_KIND     = 4'd7,
		JMP_OP       = 4'd8
	} jump_t;

	typedef enum logic [1:0] {
		MS_ADDR = 2'd0,
		MS_PC   = 2'd1,
		MS_TGT  = 2'd2
	} msrc_t;

	typedef enum logic [2:0] {
		WD_IN   = 3'd0,
		WD_FILL = 3'd1,
		WD_B0   = 3'd2,
		WD_B1   = 3'd3,
		WD_B2   = 3'd4
	} wdsel_t;

	typedef enum logic [2:0] {
		CAP_NONE   = 3'd0,
		CAP_OP     = 3'd1,
		CAP_TGT_LO = 3'd2,
		CAP_TGT_HI = 3'd3,
		CAP_W0     = 3'd4,
		CAP_W1     = 3'd5,
		CAP_RD     = 3'd6
	} cap_t;

	typedef enum logic [1:0] {
		PC_HOLD  = 2'd0,
		PC_START = 2'd1,
		PC_NEXT  = 2'd2
	} pcsel_t;

	typedef struct packed {
		jump_t  jmp;
		upc_t   tgt;
		logic   mod_start;
		msrc_t  msrc;
		logic   ma_ld;
		logic   ma_inc;
		logic   mem_rd;
		logic   mem_wr;
		wdsel_t wd;
		cap_t   cap;
		logic   alu;
		logic   regs_clr;
		logic   rd_clr;
		pcsel_t pcsel;
		logic   emit;
		logic   in_ld;
	} ctl_t;

	typedef struct packed {
		logic  mod_busy;
		logic  halted;
		logic  ma_last;
		logic  out_busy;
		kind_t kind;
		opc_t  opc;
	} sts_t;

	// Input payload: address in the low bits, then the data byte.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [ADDR_W-1:0] address;
	} in_t;

	// Result payload, last declared field (pc_now) in the low bits, padded to whole bytes.
	typedef struct packed {
		logic [4:0]        pad;
		logic [BYTE_W-1:0] read_data;
		logic              halted;
		logic [1:0]        compare_result;
		logic [WORD_W-1:0] index_value;
		logic [WORD_W-1:0] acc_value;
		logic [ADDR_W-1:0] pc_now;
	} out_t;

	localparam int IN_W  = $bits(in_t);
	localparam int OUT_W = $bits(out_t);

	// Microcode addresses.
	localparam upc_t U_CLR  = 5'd0;
	localparam upc_t U_IDLE = 5'd1;
	localparam upc_t U_DISP = 5'd2;
	localparam upc_t U_WR1  = 5'd3;
	localparam upc_t U_WR2  = 5'd4;
	localparam upc_t U_RD1  = 5'd5;
	localparam upc_t U_RD2  = 5'd6;
	localparam upc_t U_RD3  = 5'd7;
	localparam upc_t U_RST  = 5'd8;
	localparam upc_t U_EXE  = 5'd9;
	localparam upc_t U_F1   = 5'd10;
	localparam upc_t U_F2   = 5'd11;
	localparam upc_t U_F3   = 5'd12;
	localparam upc_t U_F4   = 5'd13;
	localparam upc_t U_F5   = 5'd14;
	localparam upc_t U_L0   = 5'd15;
	localparam upc_t U_L1   = 5'd16;
	localparam upc_t U_L2   = 5'd17;
	localparam upc_t U_L3   = 5'd18;
	localparam upc_t U_L4   = 5'd19;
	localparam upc_t U_L5   = 5'd20;
	localparam upc_t U_S0   = 5'd21;
	localparam upc_t U_S1   = 5'd22;
	localparam upc_t U_S2   = 5'd23;
	localparam upc_t U_S3   = 5'd24;
	localparam upc_t U_S4   = 5'd25;
	localparam upc_t U_JMP  = 5'd26;
	localparam upc_t U_EMIT = 5'd27;

	function automatic opc_t op_class(input logic [BYTE_W-1:0] op);
		opc_t c;
		unique case (op) inside
			OP_LDA, OP_LDX, OP_ADD, OP_SUB, OP_COMP: c = OPC_LOAD;
			OP_STA, OP_STX:                          c = OPC_STORE;
			default:                                 c = OPC_OTHER;
		endcase
		return c;
	endfunction

	// The control store. Memory reads are registered, so a byte fetched in one
	// step is captured in the next while the following read is issued.
	function automatic ctl_t ucode(input upc_t a);
		ctl_t c;
		c = '0;
		unique case (a)
			U_CLR: begin
				c.mem_wr = 1'b1; c.wd = WD_FILL; c.ma_inc = 1'b1; c.jmp = JMP_CLR;
			end
			U_IDLE: begin
				c.in_ld = 1'b1; c.jmp = JMP_WAIT_IN;
			end
			U_DISP: begin
				c.mod_start = 1'b1; c.msrc = MS_ADDR; c.rd_clr = 1'b1; c.jmp = JMP_KIND;
			end
			U_WR1: begin
				c.ma_ld = 1'b1; c.jmp = JMP_WAIT_MOD;
			end
			U_WR2: begin
				c.mem_wr = 1'b1; c.wd = WD_IN; c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_RD1: begin
				c.ma_ld = 1'b1; c.jmp = JMP_WAIT_MOD;
			end
			U_RD2: begin
				c.mem_rd = 1'b1;
			end
			U_RD3: begin
				c.cap = CAP_RD; c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_RST: begin
				c.regs_clr = 1'b1; c.pcsel = PC_START; c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_EXE: begin
				c.mod_start = 1'b1; c.msrc = MS_PC; c.jmp = JMP_HALT; c.tgt = U_EMIT;
			end
			U_F1: begin
				c.ma_ld = 1'b1; c.jmp = JMP_WAIT_MOD;
			end
			U_F2: begin
				c.mem_rd = 1'b1; c.ma_inc = 1'b1;
			end
			U_F3: begin
				c.cap = CAP_OP; c.mem_rd = 1'b1; c.ma_inc = 1'b1;
			end
			U_F4: begin
				c.cap = CAP_TGT_LO; c.mem_rd = 1'b1;
			end
			U_F5: begin
				c.cap = CAP_TGT_HI; c.jmp = JMP_OP;
			end
			U_L0: begin
				c.mod_start = 1'b1; c.msrc = MS_TGT;
			end
			U_L1: begin
				c.ma_ld = 1'b1; c.jmp = JMP_WAIT_MOD;
			end
			U_L2: begin
				c.mem_rd = 1'b1; c.ma_inc = 1'b1;
			end
			U_L3: begin
				c.cap = CAP_W0; c.mem_rd = 1'b1; c.ma_inc = 1'b1;
			end
			U_L4: begin
				c.cap = CAP_W1; c.mem_rd = 1'b1;
			end
			U_L5: begin
				c.alu = 1'b1; c.pcsel = PC_NEXT; c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_S0: begin
				c.mod_start = 1'b1; c.msrc = MS_TGT;
			end
			U_S1: begin
				c.ma_ld = 1'b1; c.jmp = JMP_WAIT_MOD;
			end
			U_S2: begin
				c.mem_wr = 1'b1; c.wd = WD_B0; c.ma_inc = 1'b1;
			end
			U_S3: begin
				c.mem_wr = 1'b1; c.wd = WD_B1; c.ma_inc = 1'b1;
			end
			U_S4: begin
				c.mem_wr = 1'b1; c.wd = WD_B2; c.pcsel = PC_NEXT;
				c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_JMP: begin
				c.pcsel = PC_NEXT; c.jmp = JMP_GOTO; c.tgt = U_EMIT;
			end
			U_EMIT: begin
				c.emit = 1'b1; c.jmp = JMP_WAIT_OUT; c.tgt = U_IDLE;
			end
			default: begin
				c.jmp = JMP_GOTO; c.tgt = U_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/sicx_amod.sv */
// Address reducer: a 16-bit address modulo the memory size.
module sicx_amod import sicx_pkg::*; #(
	parameter int MEM_BYTES = 1024,
	localparam int AW = $clog2(MEM_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] a,
	output logic              busy,
	output logic [AW-1:0]     r
);

	localparam bit IS_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;

	if (IS_POW2) begin : g_mask
		logic [AW-1:0] r_q;

		// A power-of-two size is a plain mask, ready the cycle after start.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				r_q <= '0;
			end else if (start) begin
				r_q <= a[AW-1:0];
			end
		end

		assign busy = 1'b0;
		assign r    = r_q;
	end else begin : g_iter
		localparam int QB = ADDR_W - AW + 1;
		localparam int CW = $clog2(QB + 1);
		localparam int RW = ADDR_W + 1;
		localparam logic [RW-1:0] D0 = RW'(MEM_BYTES) << (QB - 1);

		logic [RW-1:0] rem_q;
		logic [RW-1:0] div_q;
		logic [CW-1:0] cnt_q;

		// Restoring reduction: one shifted copy of the size per cycle.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= '0;
			end else if (start) begin
				cnt_q <= CW'(QB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= {1'b0, a};
				div_q <= D0;
			end else if (cnt_q != '0) begin
				if (rem_q >= div_q) begin
					rem_q <= rem_q - div_q;
				end
				div_q <= div_q >> 1;
			end
		end

		assign busy = cnt_q != '0;
		assign r    = rem_q[AW-1:0];
	end

endmodule

/* hw/rtl/sicx_seq.sv */
// Microcode sequencer: step counter, control store lookup and next-step selection.
module sicx_seq import sicx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t st,
	input  logic s_tvalid,
	output logic s_tready,
	output ctl_t ctl
);

	upc_t upc_q;
	upc_t upc_nxt;
	upc_t upc_inc;

	assign ctl     = ucode(upc_q);
	assign upc_inc = upc_q + upc_t'(1);
	assign s_tready = upc_q == U_IDLE;

	always_comb begin
		unique case (ctl.jmp)
			JMP_SEQ:      upc_nxt = upc_inc;
			JMP_GOTO:     upc_nxt = ctl.tgt;
			JMP_WAIT_MOD: upc_nxt = st.mod_busy ? upc_q : upc_inc;
			JMP_WAIT_IN:  upc_nxt = s_tvalid ? upc_inc : upc_q;
			JMP_WAIT_OUT: upc_nxt = st.out_busy ? upc_q : ctl.tgt;
			JMP_CLR:      upc_nxt = st.ma_last ? upc_inc : upc_q;
			JMP_HALT:     upc_nxt = st.halted ? ctl.tgt : upc_inc;
			JMP_KIND: begin
				unique case (st.kind)
					K_WRITE:   upc_nxt = U_WR1;
					K_READ:    upc_nxt = U_RD1;
					K_RESTART: upc_nxt = U_RST;
					K_STEP:    upc_nxt = U_EXE;
					default:   upc_nxt = U_IDLE;
				endcase
			end
			JMP_OP: begin
				unique case (st.opc)
					OPC_LOAD:  upc_nxt = U_L0;
					OPC_STORE: upc_nxt = U_S0;
					OPC_OTHER: upc_nxt = U_JMP;
					default:   upc_nxt = U_JMP;
				endcase
			end
			default:      upc_nxt = U_IDLE;
		endcase
	end

	// After reset the program starts with the memory clearing loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLR;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

/* hw/rtl/sicx_dp.sv */
// Datapath: byte memory, machine registers, operand assembly, ALU and result register.
module sicx_dp import sicx_pkg::*; #(
	parameter int MEM_BYTES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              st,
	input  logic [1:0]        s_tuser,
	input  logic [IN_W-1:0]   s_tdata,
	input  logic [ADDR_W-1:0] cfg_start,
	input  logic [ADDR_W-1:0] cfg_len,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int AW = $clog2(MEM_BYTES);

	logic [BYTE_W-1:0] mem [MEM_BYTES];
	logic [BYTE_W-1:0] dout_q;

	kind_t             kind_q;
	in_t               item_q;
	logic [ADDR_W-1:0] pc_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] x_q;
	logic [1:0]        cc_q;
	logic [AW-1:0]     ma_q;
	logic [BYTE_W-1:0] op_q;
	logic [ADDR_W-1:0] tgt_q;
	logic [15:0]       w_q;
	logic [BYTE_W-1:0] rd_q;
	logic              m_tvalid_q;
	out_t              out_q;

	logic [ADDR_W-1:0] mod_a;
	logic              mod_busy;
	logic [AW-1:0]     mod_r;
	logic              ma_last;
	logic [BYTE_W-1:0] wdata;
	logic [WORD_W-1:0] st_src;
	logic [WORD_W-1:0] word;
	logic              taken;
	logic              halted;
	logic              out_busy;

	always_comb begin
		unique case (ctl.msrc)
			MS_ADDR: mod_a = item_q.address;
			MS_PC:   mod_a = pc_q;
			MS_TGT:  mod_a = tgt_q;
			default: mod_a = item_q.address;
		endcase
	end

	sicx_amod #(.MEM_BYTES(MEM_BYTES)) u_amod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mod_start),
		.a      (mod_a),
		.busy   (mod_busy),
		.r      (mod_r)
	);

	assign ma_last = ma_q == AW'(MEM_BYTES - 1);

	// The memory address register also serves as the clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q <= '0;
		end else if (ctl.ma_ld) begin
			ma_q <= mod_r;
		end else if (ctl.ma_inc) begin
			ma_q <= ma_last ? '0 : ma_q + AW'(1);
		end
	end

	assign st_src = (op_q == OP_STX) ? x_q : acc_q;

	always_comb begin
		unique case (ctl.wd)
			WD_IN:   wdata = item_q.data;
			WD_FILL: wdata = FILL_BYTE;
			WD_B0:   wdata = st_src[7:0];
			WD_B1:   wdata = st_src[15:8];
			WD_B2:   wdata = st_src[23:16];
			default: wdata = FILL_BYTE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[ma_q] <= wdata;
		end
		if (ctl.mem_rd) begin
			dout_q <= mem[ma_q];
		end
	end

	// Item registers follow the bus while waiting; the accepted item stays.
	always_ff @(posedge clk) begin
		if (ctl.in_ld) begin
			kind_q <= kind_t'(s_tuser);
			item_q <= in_t'(s_tdata);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cap)
			CAP_OP:     op_q        <= dout_q;
			CAP_TGT_LO: tgt_q[7:0]  <= dout_q;
			CAP_TGT_HI: tgt_q[15:8] <= dout_q;
			CAP_W0:     w_q[7:0]    <= dout_q;
			CAP_W1:     w_q[15:8]   <= dout_q;
			default: ;
		endcase
		if (ctl.rd_clr) begin
			rd_q <= '0;
		end else if (ctl.cap == CAP_RD) begin
			rd_q <= dout_q;
		end
	end

	// The top operand byte is used straight from the memory read register.
	assign word = {dout_q, w_q};

	assign taken = (op_q == OP_JEQ && cc_q == CC_EQ) ||
	               (op_q == OP_JGT && cc_q == CC_GT) ||
	               (op_q == OP_JLT && cc_q == CC_LT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			acc_q <= '0;
			x_q   <= '0;
			cc_q  <= CC_EQ;
		end else begin
			if (ctl.regs_clr) begin
				acc_q <= '0;
				x_q   <= '0;
				cc_q  <= CC_EQ;
			end else if (ctl.alu) begin
				unique case (op_q)
					OP_LDA: acc_q <= word;
					OP_LDX: x_q   <= word;
					OP_ADD: acc_q <= acc_q + word;
					OP_SUB: acc_q <= acc_q - word;
					OP_COMP: begin
						if (acc_q == word) begin
							cc_q <= CC_EQ;
						end else if (acc_q > word) begin
							cc_q <= CC_GT;
						end else begin
							cc_q <= CC_LT;
						end
					end
					default: ;
				endcase
			end
			case (ctl.pcsel)
				PC_START: pc_q <= cfg_start;
				PC_NEXT:  pc_q <= taken ? tgt_q : pc_q + ADDR_W'(3);
				default: ;
			endcase
		end
	end

	assign halted = {1'b0, pc_q} >= ({1'b0, cfg_start} + {1'b0, cfg_len});

	assign out_busy = m_tvalid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit && !out_busy) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && !out_busy) begin
			out_q.pad            <= '0;
			out_q.read_data      <= rd_q;
			out_q.halted         <= halted;
			out_q.compare_result <= cc_q;
			out_q.index_value    <= x_q;
			out_q.acc_value      <= acc_q;
			out_q.pc_now         <= pc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	assign st.mod_busy = mod_busy;
	assign st.halted   = halted;
	assign st.ma_last  = ma_last;
	assign st.out_busy = out_busy;
	assign st.kind     = kind_q;
	assign st.opc      = op_class(op_q);

endmodule

/* hw/rtl/sic_subset_execution_core_top.sv */
// Top level of the SIC subset execution core: stream ports, APB registers, sequencer and datapath.
//
// A small SIC-style machine with a byte memory of MEM_BYTES entries behind a
// single port. Each request on the slave stream writes a byte, reads a byte,
// restarts the program, or executes one 3-byte instruction at PC, and each one
// yields exactly one result transfer holding PC, A, X, the condition code, the
// halted flag and the read byte. Control comes from a microcode store stepped
// by a program counter, and memory reads are registered. With a power-of-two
// memory size, a restart or a step while halted occupies the block the shortest
// time, followed in order by a byte write, a byte read, a jump or unknown
// opcode, a store, and a load, add, subtract or compare, measured from one
// accepted request to the next when results are taken at once. With any other
// size, each address reduction also runs an iterative unit, once for a byte
// access and twice for an operand instruction. After reset the memory is
// filled with 0xFF; requests are held off during that sweep, while register
// writes are taken as usual. A finished result waits in an output register,
// so the next request can be accepted while the master side stalls.
// Registers: start address at byte address 0, code length at byte address 4;
// write them only while no request is outstanding.
module sic_subset_execution_core_top import sicx_pkg::*; #(
	parameter int MEM_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // [15:0] address, [23:16] data
	input  logic [1:0]         s_tuser,   // [1:0] kind
	// Result stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	// [15:0] pc_now, [39:16] acc_value, [63:40] index_value,
	// [65:64] compare_result, [66] halted, [74:67] read_data, [79:75] zero
	output logic [OUT_W-1:0]   m_tdata,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] len_q;
	logic              reg_wr;
	ctl_t              ctl;
	sts_t              st;

	// Register decode uses only the word select bit; pready never stalls.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= '0;
		end else if (reg_wr) begin
			if (paddr[PADDR_W-1] == REG_START) begin
				start_q <= pwdata[ADDR_W-1:0];
			end else begin
				len_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[PADDR_W-1] == REG_START) begin
			prdata = {(PDATA_W - ADDR_W)'(0), start_q};
		end else begin
			prdata = {(PDATA_W - ADDR_W)'(0), len_q};
		end
	end

	// The sequencer owns the request handshake; the datapath owns the result.
	sicx_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ctl      (ctl)
	);

	sicx_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_start (start_q),
		.cfg_len   (len_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* hw/rtl/sicx_checker.sv */
// Port-level checker for the SIC subset core, bound to the top level.
module sicx_checker import sicx_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [1:0]         s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [OUT_W-1:0]   m_tdata,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic               pready
);

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] len_q;
	kind_t             kinds_q [2];
	logic              wp_q;
	logic              rp_q;
	logic              in_xfer;
	logic              out_xfer;
	kind_t             out_kind;
	out_t              res;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign out_kind = kinds_q[rp_q];
	assign res      = out_t'(m_tdata);

	// Shadow of the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[PADDR_W-1] == REG_START) begin
				start_q <= pwdata[ADDR_W-1:0];
			end else begin
				len_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	// At most two requests are outstanding: one result waiting, one in work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				wp_q <= !wp_q;
			end
			if (out_xfer) begin
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kinds_q[wp_q] <= kind_t'(s_tuser);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_cc_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.compare_result == CC_EQ || res.compare_result == CC_GT ||
		              res.compare_result == CC_LT))
		else $error("condition code outside equal, greater, less");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_kind == K_RESTART |->
			res.pc_now == start_q && res.acc_value == '0 &&
			res.index_value == '0 && res.compare_result == CC_EQ)
		else $error("restart did not load the start address and clear registers");

	a_halted: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> res.halted == ({1'b0, res.pc_now} >= ({1'b0, start_q} + {1'b0, len_q})))
		else $error("halted flag disagrees with PC and code range");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_kind != K_READ |-> res.read_data == '0)
		else $error("read byte not zero for a request other than a read");

endmodule

bind sic_subset_execution_core_top sicx_checker u_sicx_checker (.*);
